[design/wga_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wga_pkg
// shared types, widths and the saturating accumulate for the weighted gram
// matrix accumulator
// ----------------------------------------------------------------------------
package wga_pkg;

   localparam int unsigned COLS_MAX = 8;
   localparam int unsigned DATA_W   = 16;
   localparam int unsigned WX_W     = 2 * DATA_W;
   localparam int unsigned PROD_W   = 3 * DATA_W;
   localparam int unsigned SUM_W    = 64;
   localparam int unsigned ENERGY_W = 63;
   localparam int unsigned CNT_W    = 4;

   localparam logic [CNT_W-1:0] CFG_COLS_RESET = CNT_W'(8);

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] x_col0;
      logic signed [DATA_W-1:0] x_col1;
      logic signed [DATA_W-1:0] x_col2;
      logic signed [DATA_W-1:0] x_col3;
      logic signed [DATA_W-1:0] x_col4;
      logic signed [DATA_W-1:0] x_col5;
      logic signed [DATA_W-1:0] x_col6;
      logic signed [DATA_W-1:0] x_col7;
      logic signed [DATA_W-1:0] row_weight;
      logic signed [DATA_W-1:0] row_response;
      logic                     last_row;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] gram_c0;
      logic signed [SUM_W-1:0] gram_c1;
      logic signed [SUM_W-1:0] gram_c2;
      logic signed [SUM_W-1:0] gram_c3;
      logic signed [SUM_W-1:0] gram_c4;
      logic signed [SUM_W-1:0] gram_c5;
      logic signed [SUM_W-1:0] gram_c6;
      logic signed [SUM_W-1:0] gram_c7;
      logic signed [SUM_W-1:0] weighted_cross;
      logic [ENERGY_W-1:0]     weighted_energy;
      logic                    weight_error;
      logic                    last_result;
   } rsp_type;

   // accumulate stage control, aligned with the registered products
   typedef struct packed {
      logic             add;
      logic             bad;
      logic [CNT_W-1:0] cols;
   } acc_ctl_type;

   // readout control: shift moves one matrix row out, clear ends the batch
   typedef struct packed {
      logic shift;
      logic clear;
   } emit_ctl_type;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0]  acc,
      input logic signed [PROD_W-1:0] inc
   );
      logic signed [SUM_W:0] sum;
      sum = {acc[SUM_W-1], acc} + {{(SUM_W+1-PROD_W){inc[PROD_W-1]}}, inc};
      if (sum[SUM_W] != sum[SUM_W-1]) begin
         return sum[SUM_W] ? SUM_MIN : SUM_MAX;
      end
      return sum[SUM_W-1:0];
   endfunction

endpackage

[design/wga_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wga_lane
// one matrix column: w*x multiply, products against every column and the
// response, saturating accumulators, shift-out readout
// ----------------------------------------------------------------------------
module wga_lane #(
   parameter int unsigned COLS = wga_pkg::COLS_MAX,
   parameter int unsigned LANE = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [wga_pkg::DATA_W-1:0]      weight_a,
   input  logic signed [wga_pkg::DATA_W-1:0]      x_own_a,
   input  logic [COLS-1:0][wga_pkg::DATA_W-1:0]   x_b,
   input  logic signed [wga_pkg::DATA_W-1:0]      z_b,
   input  wga_pkg::acc_ctl_type                   acc_ctl,
   input  wga_pkg::emit_ctl_type                  emit_ctl,
   input  logic signed [wga_pkg::SUM_W-1:0]       cross_in,
   output logic signed [wga_pkg::SUM_W-1:0]       gram_head,
   output logic signed [wga_pkg::SUM_W-1:0]       cross_out
);
   import wga_pkg::*;

   logic signed [WX_W-1:0]   wx_ff;
   logic signed [PROD_W-1:0] prod_ff [COLS];
   logic signed [PROD_W-1:0] cross_prod_ff;
   logic signed [SUM_W-1:0]  acc_ff [COLS];
   logic signed [SUM_W-1:0]  acc_in [COLS];
   logic signed [SUM_W-1:0]  cross_ff;
   logic signed [SUM_W-1:0]  cross_in_nxt;
   logic                     lane_on;

   assign lane_on = (CNT_W'(LANE) < acc_ctl.cols) && acc_ctl.add;

   always_ff @(posedge clock) begin
      wx_ff         <= weight_a * x_own_a;
      cross_prod_ff <= wx_ff * z_b;
   end

   for (genvar r = 0; r < COLS; r++) begin : g_ent
      logic signed [SUM_W-1:0] below;

      if (r == COLS - 1) begin : g_end
         assign below = '0;
      end else begin : g_mid
         assign below = acc_ff[r+1];
      end

      always_ff @(posedge clock) begin
         prod_ff[r] <= wx_ff * $signed(x_b[r]);
      end

      always_comb begin
         acc_in[r] = acc_ff[r];
         if (emit_ctl.clear) begin
            acc_in[r] = '0;
         end else if (emit_ctl.shift) begin
            acc_in[r] = below;
         end else if (lane_on && (CNT_W'(r) < acc_ctl.cols)) begin
            acc_in[r] = sat_add(acc_ff[r], prod_ff[r]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            acc_ff[r] <= '0;
         end else begin
            acc_ff[r] <= acc_in[r];
         end
      end
   end

   always_comb begin
      cross_in_nxt = cross_ff;
      if (emit_ctl.clear) begin
         cross_in_nxt = '0;
      end else if (emit_ctl.shift) begin
         cross_in_nxt = cross_in;
      end else if (lane_on) begin
         cross_in_nxt = sat_add(cross_ff, cross_prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cross_ff <= '0;
      end else begin
         cross_ff <= cross_in_nxt;
      end
   end

   assign gram_head = acc_ff[0];
   assign cross_out = cross_ff;

endmodule

[design/wga_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wga_merge
// energy accumulator, batch error flag and the result register that gathers
// the lane heads into one result beat
// ----------------------------------------------------------------------------
module wga_merge #(
   parameter int unsigned COLS = wga_pkg::COLS_MAX
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [wga_pkg::DATA_W-1:0]     weight_a,
   input  logic signed [wga_pkg::DATA_W-1:0]     z_a,
   input  logic signed [wga_pkg::DATA_W-1:0]     z_b,
   input  wga_pkg::acc_ctl_type                  acc_ctl,
   input  wga_pkg::emit_ctl_type                 emit_ctl,
   input  logic [wga_pkg::CNT_W-1:0]             emit_cols,
   input  logic [COLS-1:0][wga_pkg::SUM_W-1:0]   gram_heads,
   input  logic signed [wga_pkg::SUM_W-1:0]      cross_head,
   output logic                                  rsp_valid,
   output wga_pkg::rsp_type                      rsp_payload
);
   import wga_pkg::*;

   logic signed [WX_W-1:0]   wz_ff;
   logic signed [PROD_W-1:0] wzz_ff;
   logic signed [SUM_W-1:0]  energy_ff;
   logic                     bad_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;
   logic [COLS_MAX-1:0][SUM_W-1:0] gram_full;

   always_ff @(posedge clock) begin
      wz_ff  <= weight_a * z_a;
      wzz_ff <= wz_ff * z_b;
   end

   always_ff @(posedge clock) begin
      if (reset || emit_ctl.clear) begin
         energy_ff <= '0;
         bad_ff    <= 1'b0;
      end else begin
         if (acc_ctl.add) begin
            energy_ff <= sat_add(energy_ff, wzz_ff);
         end
         if (acc_ctl.bad) begin
            bad_ff <= 1'b1;
         end
      end
   end

   // columns outside the count in use read as zero
   for (genvar c = 0; c < COLS_MAX; c++) begin : g_col
      if (c < COLS) begin : g_on
         assign gram_full[c] = (CNT_W'(c) < emit_cols) ? gram_heads[c] : '0;
      end else begin : g_off
         assign gram_full[c] = '0;
      end
   end

   always_comb begin
      rsp_in.gram_c0         = gram_full[0];
      rsp_in.gram_c1         = gram_full[1];
      rsp_in.gram_c2         = gram_full[2];
      rsp_in.gram_c3         = gram_full[3];
      rsp_in.gram_c4         = gram_full[4];
      rsp_in.gram_c5         = gram_full[5];
      rsp_in.gram_c6         = gram_full[6];
      rsp_in.gram_c7         = gram_full[7];
      rsp_in.weighted_cross  = cross_head;
      rsp_in.weighted_energy = energy_ff[ENERGY_W-1:0];
      rsp_in.weight_error    = bad_ff;
      rsp_in.last_result     = emit_ctl.clear;
   end

   always_ff @(posedge clock) begin
      if (emit_ctl.shift) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit_ctl.shift;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[design/weighted_gram_accumulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_gram_accumulator
// accumulates the weighted gram matrix, cross terms and energy of a batch of
// rows and reads out one mirrored matrix row per result beat on the last row
// ----------------------------------------------------------------------------
//
// channel   ports                               direction  handshake
// request   start, busy, req_payload            in         start & !busy
// result    rsp_valid, rsp_payload              out        strobe, no stall
// config    csr_valid, csr_ready, csr_data      in         valid & ready
//
// - a row that is not last is taken every cycle while busy is low; it runs
//   through input register, w*x multiply, product and accumulate stages
// - a last row holds busy while it runs through the pipeline and while the
//   lanes shift their matrix rows out, one row per column in use
// - result beats come on consecutive cycles and cannot be held off
// - synchronous reset clears all sums, the error flag and sets the column
//   count to 8
//
module weighted_gram_accumulator #(
   parameter int unsigned COLS = wga_pkg::COLS_MAX
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  wga_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   output wga_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wga_pkg::CNT_W-1:0]     csr_data
);
   import wga_pkg::*;

   localparam logic [CNT_W-1:0] COLS_CNT = CNT_W'(COLS);

   // configuration register and its clamped view
   logic [CNT_W-1:0] csr_cols_ff;
   logic [CNT_W-1:0] cols_clamped;

   // handshake and batch readout control
   logic             accept;
   logic             busy_ff;
   logic             emit_ff;
   logic [CNT_W-1:0] emit_row_ff;
   logic [CNT_W-1:0] emit_cols_ff;

   // pipeline control: a = input register, b = w*x, c = products
   logic             a_vld_ff, b_vld_ff, c_vld_ff;
   logic             b_ok_ff, c_ok_ff;
   logic             b_last_ff, c_last_ff;
   logic [CNT_W-1:0] a_cols_ff, b_cols_ff, c_cols_ff;
   logic             a_last_ff;

   // row payload along the stages
   req_type                           req_ff;
   logic [COLS_MAX-1:0][DATA_W-1:0]   x_a;
   logic [COLS-1:0][DATA_W-1:0]       x_b_ff;
   logic signed [DATA_W-1:0]          z_b_ff;

   acc_ctl_type  acc_ctl;
   emit_ctl_type emit_ctl;

   logic [COLS-1:0][SUM_W-1:0] gram_heads;
   logic [COLS:0][SUM_W-1:0]   cross_chain;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   // a count of zero acts as one, anything above the lane count as the lane count
   always_comb begin
      if (csr_cols_ff == '0) begin
         cols_clamped = CNT_W'(1);
      end else if (csr_cols_ff > COLS_CNT) begin
         cols_clamped = COLS_CNT;
      end else begin
         cols_clamped = csr_cols_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_cols_ff <= CFG_COLS_RESET;
      end else if (csr_valid && csr_ready) begin
         csr_cols_ff <= csr_data;
      end
   end

   // input beat register, column count sampled with the row
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff    <= req_payload;
         a_cols_ff <= cols_clamped;
         a_last_ff <= req_payload.last_row;
      end
   end

   assign x_a[0] = req_ff.x_col0;
   assign x_a[1] = req_ff.x_col1;
   assign x_a[2] = req_ff.x_col2;
   assign x_a[3] = req_ff.x_col3;
   assign x_a[4] = req_ff.x_col4;
   assign x_a[5] = req_ff.x_col5;
   assign x_a[6] = req_ff.x_col6;
   assign x_a[7] = req_ff.x_col7;

   // row data delayed to line up with w*x in the product stage
   always_ff @(posedge clock) begin
      x_b_ff    <= x_a[COLS-1:0];
      z_b_ff    <= req_ff.row_response;
      b_cols_ff <= a_cols_ff;
      b_last_ff <= a_last_ff;
      b_ok_ff   <= !req_ff.row_weight[DATA_W-1];
      c_cols_ff <= b_cols_ff;
      c_last_ff <= b_last_ff;
      c_ok_ff   <= b_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= accept;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   // negative weight: row adds nothing, error flag is raised for the batch
   assign acc_ctl.add  = c_vld_ff && c_ok_ff;
   assign acc_ctl.bad  = c_vld_ff && !c_ok_ff;
   assign acc_ctl.cols = c_cols_ff;

   assign emit_ctl.shift = emit_ff;
   assign emit_ctl.clear = emit_ff && (emit_row_ff == (emit_cols_ff - CNT_W'(1)));

   // busy from a last row accept until the final result beat is registered
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         emit_ff      <= 1'b0;
         emit_row_ff  <= '0;
         emit_cols_ff <= CNT_W'(1);
      end else begin
         if (accept && req_payload.last_row) begin
            busy_ff <= 1'b1;
         end else if (emit_ctl.clear) begin
            busy_ff <= 1'b0;
         end

         if (c_vld_ff && c_last_ff) begin
            emit_ff      <= 1'b1;
            emit_row_ff  <= '0;
            emit_cols_ff <= c_cols_ff;
         end else if (emit_ctl.clear) begin
            emit_ff <= 1'b0;
         end else if (emit_ff) begin
            emit_row_ff <= emit_row_ff + CNT_W'(1);
         end
      end
   end

   // one lane per column; cross terms shift toward lane 0 during readout
   assign cross_chain[COLS] = '0;

   for (genvar l = 0; l < COLS; l++) begin : g_lane
      wga_lane #(
         .COLS (COLS),
         .LANE (l)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .weight_a  (req_ff.row_weight),
         .x_own_a   ($signed(x_a[l])),
         .x_b       (x_b_ff),
         .z_b       (z_b_ff),
         .acc_ctl   (acc_ctl),
         .emit_ctl  (emit_ctl),
         .cross_in  (cross_chain[l+1]),
         .gram_head (gram_heads[l]),
         .cross_out (cross_chain[l])
      );
   end

   // energy, error flag and the result register
   wga_merge #(
      .COLS (COLS)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .weight_a    (req_ff.row_weight),
      .z_a         (req_ff.row_response),
      .z_b         (z_b_ff),
      .acc_ctl     (acc_ctl),
      .emit_ctl    (emit_ctl),
      .emit_cols   (emit_cols_ff),
      .gram_heads  (gram_heads),
      .cross_head  ($signed(cross_chain[0])),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // busy drops only together with the final result beat of a batch
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> (rsp_valid && rsp_payload.last_result))
      else $error("busy dropped without a final result beat");

   // readout never overlaps accumulation
   a_no_acc_in_emit: assert property (@(posedge clock) disable iff (reset)
      emit_ff |-> !c_vld_ff)
      else $error("row accumulated during readout");

   // result beats of a batch come back to back
   a_rsp_contig: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.last_result) |=> rsp_valid)
      else $error("gap inside a batch readout");

endmodule
